// ----- hw/rtl/mtts_pkg.sv -----
// mtts_pkg: constants and types shared by the motion step core
// no dependencies

package mtts_pkg;

    localparam int SqrtSteps = 34;
    localparam int DivSteps  = 16;
    localparam int SqrtBase  = 4;
    localparam int DivBase   = SqrtBase + SqrtSteps;
    localparam int HeadStg   = DivBase + DivSteps;
    localparam int NumStg    = HeadStg + 1;
    localparam int Latency   = HeadStg + 2;

    localparam logic [30:0] ThreshReset = 31'd6554;
    localparam logic [2:0]  AddrThresh  = 3'd0;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] dst;
        logic [2:0][15:0] head;
        logic [30:0]      speed;
        logic [30:0]      move;
        logic             active;
        logic [2:0]       neg;
        logic [2:0][32:0] mag;
        logic [33:0]      dlen;
        logic             arr;
        logic             ovr;
    } t_item;

endpackage

// ----- hw/rtl/move_toward_target_step_core.sv -----
// move_toward_target_step_core: pipelined one-step agent motion update
// depends on mtts_pkg

// usage
//   a word is taken at each rising edge with start high; busy stays low, so
//   a new agent record may enter every cycle
//   each result appears on the o_new_* ports for one cycle with o_done high;
//   one result per cycle sustained
//   the pipeline is made of the 34-step square root and the 16-step heading
//   divide, each one bit per stage, plus four front stages for capture,
//   differences, squares and their sum, one heading stage and the result
//   register
//   arrival_threshold sits at byte address 0 of the apb port, reset 6554
//   reset clears the stage valid bits and reloads the threshold; records in
//   flight are dropped
//   the receiver cannot stall, results are never held back

module move_toward_target_step_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_dest_x,
    input  logic signed [31:0] i_dest_y,
    input  logic signed [31:0] i_dest_z,
    input  logic signed [15:0] i_head_x,
    input  logic signed [15:0] i_head_y,
    input  logic signed [15:0] i_head_z,
    input  logic [30:0]        i_speed,
    input  logic [15:0]        i_time_step,
    input  logic               i_active,
    output logic               o_done,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_pos_z,
    output logic signed [15:0] o_new_head_x,
    output logic signed [15:0] o_new_head_y,
    output logic signed [15:0] o_new_head_z,
    output logic [30:0]        o_new_speed,
    output logic               o_still_active,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [30:0] r_thr;
    mtts_pkg::t_item r_it [0:mtts_pkg::NumStg-1];
    logic [mtts_pkg::NumStg-1:0] r_v;

    logic [2:0][65:0] r_sq;
    logic [67:0] r_rad  [0:mtts_pkg::SqrtSteps];
    logic [36:0] r_rem  [0:mtts_pkg::SqrtSteps];
    logic [33:0] r_root [0:mtts_pkg::SqrtSteps];

    logic [2:0][35:0] r_dr [1:mtts_pkg::DivSteps];
    logic [2:0][15:0] r_dq [1:mtts_pkg::DivSteps];

    logic [2:0][15:0] r_nh;
    logic [2:0][31:0] r_stp;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mtts_pkg::ThreshReset;
        end else if (psel && penable && pwrite && paddr[2:2] == mtts_pkg::AddrThresh[2:2]) begin
            r_thr <= pwdata[30:0];
        end
    end

    always_comb begin
        if (paddr[2:2] == mtts_pkg::AddrThresh[2:2]) begin
            prdata = {1'b0, r_thr};
        end else begin
            prdata = 32'd0;
        end
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[mtts_pkg::NumStg-2:0], start};
        end
    end

    // capture
    always_ff @(posedge i_clk) begin
        mtts_pkg::t_item it;
        it        = '0;
        it.pos    = {i_pos_z, i_pos_y, i_pos_x};
        it.dst    = {i_dest_z, i_dest_y, i_dest_x};
        it.head   = {i_head_z, i_head_y, i_head_x};
        it.speed  = i_speed;
        it.move   = {15'd0, i_time_step};
        it.active = i_active;
        r_it[0]  <= it;
    end

    // differences, magnitudes and move length
    always_ff @(posedge i_clk) begin
        mtts_pkg::t_item it;
        logic [32:0] d;
        logic [46:0] pr;
        it = r_it[0];
        for (int i = 0; i < 3; i++) begin
            d = {it.dst[i][31], it.dst[i]} - {it.pos[i][31], it.pos[i]};
            it.neg[i] = d[32];
            it.mag[i] = d[32] ? (33'd0 - d) : d;
        end
        pr = it.speed * it.move[15:0];
        it.move = pr[46:16];
        r_it[1] <= it;
    end

    // squares
    always_ff @(posedge i_clk) begin
        r_it[2] <= r_it[1];
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= r_it[1].mag[i] * r_it[1].mag[i];
        end
    end

    // sum of squares
    always_ff @(posedge i_clk) begin
        r_it[3]   <= r_it[2];
        r_rad[0]  <= {2'b00, r_sq[0] + r_sq[1] + r_sq[2]};
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < mtts_pkg::SqrtSteps; k++) begin : g_sqrt
        logic [36:0] rem_sh;
        logic [36:0] trial;
        logic        ge;
        assign rem_sh = {r_rem[k][34:0], r_rad[k][67:66]};
        assign trial  = {1'b0, r_root[k], 2'b01};
        assign ge     = rem_sh >= trial;
        always_ff @(posedge i_clk) begin
            r_it[mtts_pkg::SqrtBase+k] <= r_it[mtts_pkg::SqrtBase+k-1];
            r_rad[k+1]  <= {r_rad[k][65:0], 2'b00};
            r_rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
            r_root[k+1] <= {r_root[k][32:0], ge};
        end
    end

    // heading divide, one quotient bit per stage for each axis
    for (genvar j = 0; j < mtts_pkg::DivSteps; j++) begin : g_div
        logic [33:0]      dlen;
        logic [2:0][35:0] rin;
        logic [2:0][15:0] qin;
        logic [2:0]       ge;
        if (j == 0) begin : g_first
            assign dlen = r_root[mtts_pkg::SqrtSteps];
            for (genvar i = 0; i < 3; i++) begin : g_l
                assign rin[i] = {3'b000, r_it[mtts_pkg::DivBase-1].mag[i]};
                assign qin[i] = '0;
            end
        end else begin : g_rest
            assign dlen = r_it[mtts_pkg::DivBase+j-1].dlen;
            for (genvar i = 0; i < 3; i++) begin : g_l
                assign rin[i] = {r_dr[j][i][34:0], 1'b0};
                assign qin[i] = r_dq[j][i];
            end
        end
        for (genvar i = 0; i < 3; i++) begin : g_cmp
            assign ge[i] = rin[i] >= {2'b00, dlen};
        end
        always_ff @(posedge i_clk) begin
            mtts_pkg::t_item it;
            it = r_it[mtts_pkg::DivBase+j-1];
            if (j == 0) begin
                it.dlen = dlen;
                it.arr  = (dlen == 34'd0) || (dlen < {3'b000, r_thr});
                it.ovr  = {3'b000, it.move} > dlen;
            end
            r_it[mtts_pkg::DivBase+j] <= it;
            for (int i = 0; i < 3; i++) begin
                r_dr[j+1][i] <= ge[i] ? (rin[i] - {2'b00, dlen}) : rin[i];
                r_dq[j+1][i] <= {qin[i][14:0], ge[i]};
            end
        end
    end

    // saturated heading and per-axis step length
    always_ff @(posedge i_clk) begin
        logic [15:0] q;
        logic [15:0] hm;
        logic [46:0] pr;
        r_it[mtts_pkg::HeadStg] <= r_it[mtts_pkg::HeadStg-1];
        for (int i = 0; i < 3; i++) begin
            q = r_dq[mtts_pkg::DivSteps][i];
            if (r_it[mtts_pkg::HeadStg-1].neg[i]) begin
                hm = (q > 16'd32768) ? 16'd32768 : q;
                r_nh[i] <= 16'd0 - hm;
            end else begin
                hm = (q > 16'd32767) ? 16'd32767 : q;
                r_nh[i] <= hm;
            end
            pr = hm * r_it[mtts_pkg::HeadStg-1].move;
            r_stp[i] <= pr[46:15];
        end
    end

    // result select
    always_ff @(posedge i_clk) begin
        mtts_pkg::t_item it;
        logic [2:0][31:0] np;
        logic [2:0][15:0] nh;
        logic [30:0] sp;
        logic act;
        it = r_it[mtts_pkg::HeadStg];
        np = it.pos;
        nh = it.head;
        sp = it.speed;
        act = 1'b0;
        if (it.active) begin
            if (it.arr) begin
                sp = '0;
            end else if (it.ovr) begin
                nh = r_nh;
                np = it.dst;
                sp = '0;
            end else begin
                nh = r_nh;
                for (int i = 0; i < 3; i++) begin
                    np[i] = it.neg[i] ? (it.pos[i] - r_stp[i]) : (it.pos[i] + r_stp[i]);
                end
                act = 1'b1;
            end
        end
        o_new_pos_x    <= np[0];
        o_new_pos_y    <= np[1];
        o_new_pos_z    <= np[2];
        o_new_head_x   <= nh[0];
        o_new_head_y   <= nh[1];
        o_new_head_z   <= nh[2];
        o_new_speed    <= sp;
        o_still_active <= act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_v[mtts_pkg::HeadStg];
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, mtts_pkg::Latency))
        else $error("result without a start word");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[mtts_pkg::DivBase-1] |->
            r_rem[mtts_pkg::SqrtSteps] <= {2'b00, r_root[mtts_pkg::SqrtSteps], 1'b0})
        else $error("square root remainder out of range");

    a_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[mtts_pkg::HeadStg-1] && !r_it[mtts_pkg::HeadStg-1].arr |->
            r_dq[mtts_pkg::DivSteps][0] <= 16'd32768 &&
            r_dq[mtts_pkg::DivSteps][1] <= 16'd32768 &&
            r_dq[mtts_pkg::DivSteps][2] <= 16'd32768)
        else $error("heading quotient above unity");

endmodule

// ----- verif/move_toward_target_step_checker.sv -----
// move_toward_target_step_checker: watches the record and result channels of the
// motion step core, predicts each result and compares it as a whole word, printing the fields on a mismatch
// depends on mtts_pkg

module move_toward_target_step_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_dest_x,
    input  logic signed [31:0] i_dest_y,
    input  logic signed [31:0] i_dest_z,
    input  logic signed [15:0] i_head_x,
    input  logic signed [15:0] i_head_y,
    input  logic signed [15:0] i_head_z,
    input  logic [30:0]        i_speed,
    input  logic [15:0]        i_time_step,
    input  logic               i_active,
    input  logic               o_done,
    input  logic signed [31:0] o_new_pos_x,
    input  logic signed [31:0] o_new_pos_y,
    input  logic signed [31:0] o_new_pos_z,
    input  logic signed [15:0] o_new_head_x,
    input  logic signed [15:0] o_new_head_y,
    input  logic signed [15:0] o_new_head_z,
    input  logic [30:0]        o_new_speed,
    input  logic               o_still_active,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][15:0] head;
        logic [30:0]      speed;
        logic             act;
    } t_agent_out;

    t_agent_out  step_results_q[$];
    logic [30:0] thresh;
    int          fails;

    function automatic logic [33:0] floor_sqrt(logic [65:0] s);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if ({34'd0, c} * {34'd0, c} <= {2'd0, s})
                r = c;
        end
        return r;
    endfunction

    function automatic t_agent_out step_agent(
        logic [2:0][31:0] p, logic [2:0][31:0] t, logic [2:0][15:0] h,
        logic [30:0] spd, logic [15:0] ts, logic act, logic [30:0] thr);
        t_agent_out  r;
        logic signed [32:0] d[3];
        logic [32:0] m[3];
        logic [65:0] sq;
        logic [33:0] dlen;
        logic [63:0] q;
        logic [46:0] mv;
        logic [63:0] st;
        logic [15:0] hm;
        logic signed [15:0] nh[3];
        r.pos = p;
        r.head = h;
        r.speed = spd;
        r.act = 1'b0;
        if (act) begin
            sq = '0;
            for (int i = 0; i < 3; i++) begin
                d[i] = $signed({p[i][31], p[i]});
                d[i] = $signed({t[i][31], t[i]}) - d[i];
                m[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
                sq += {33'd0, m[i]} * {33'd0, m[i]};
            end
            dlen = floor_sqrt(sq);
            if (dlen == 0 || dlen < {3'd0, thr}) begin
                r.speed = '0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    q = ({31'd0, m[i]} << 15) / {30'd0, dlen};
                    if (d[i] < 0)
                        nh[i] = q > 32768 ? -16'sd32768 : 16'(-q);
                    else
                        nh[i] = q > 32767 ? 16'sd32767 : 16'(q);
                    r.head[i] = nh[i];
                end
                mv = ({16'd0, spd} * {31'd0, ts}) >> 16;
                if ({17'd0, mv} > {17'd0, dlen}) begin
                    r.pos = t;
                    r.speed = '0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        hm = nh[i] < 0 ? 16'(-nh[i]) : 16'(nh[i]);
                        st = ({48'd0, hm} * {17'd0, mv}) >> 15;
                        r.pos[i] = nh[i] < 0 ? p[i] - st[31:0] : p[i] + st[31:0];
                    end
                    r.act = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign o_fail_count = fails;
    assign o_pending    = step_results_q.size();

    always @(posedge i_clk) begin
        t_agent_out got;
        t_agent_out want;
        if (!i_rst_n) begin
            thresh <= mtts_pkg::ThreshReset;
            step_results_q.delete();
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == mtts_pkg::AddrThresh)
                thresh <= pwdata[30:0];
            if (o_done) begin
                got.pos   = {o_new_pos_z, o_new_pos_y, o_new_pos_x};
                got.head  = {o_new_head_z, o_new_head_y, o_new_head_x};
                got.speed = o_new_speed;
                got.act   = o_still_active;
                if (step_results_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word: %h", got);
                end else begin
                    want = step_results_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch exp/got: pos %h/%h head %h/%h",
                                want.pos, got.pos, want.head, got.head,
                                " spd %h/%h act %b/%b",
                                want.speed, got.speed, want.act, got.act);
                    end
                end
            end
            if (start && !busy)
                step_results_q.push_back(step_agent(
                    {i_pos_z, i_pos_y, i_pos_x}, {i_dest_z, i_dest_y, i_dest_x},
                    {i_head_z, i_head_y, i_head_x}, i_speed, i_time_step,
                    i_active, thresh));
        end
    end
endmodule

// ----- verif/move_toward_target_step_core_tb.sv -----
// move_toward_target_step_core_tb: drives agent records and threshold writes into
// the motion step core and reports the verdict
// depends on mtts_pkg, move_toward_target_step_core and move_toward_target_step_checker

module move_toward_target_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_dest_x, i_dest_y, i_dest_z;
    logic signed [15:0] i_head_x, i_head_y, i_head_z;
    logic [30:0]        i_speed;
    logic [15:0]        i_time_step;
    logic               i_active;
    logic               o_done;
    logic signed [31:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic signed [15:0] o_new_head_x, o_new_head_y, o_new_head_z;
    logic [30:0]        o_new_speed;
    logic               o_still_active;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    move_toward_target_step_core DUT (.*);
    move_toward_target_step_checker u_checker (.*, .o_fail_count(fail_count),
        .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    task automatic write_thresh(logic [31:0] v);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; paddr = mtts_pkg::AddrThresh; pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic drain;
        while (pending != 0)
            @(negedge i_clk);
        repeat (mtts_pkg::Latency + 4) @(negedge i_clk);
    endtask

    // random 32-bit coordinate: mostly moderate, sometimes full range
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
        endcase
    endfunction

    task automatic send_agent(logic [31:0] px, py, pz, dx, dy, dz,
                              logic [15:0] hx, hy, hz, logic [30:0] spd,
                              logic [15:0] ts, logic act, bit allow_gap);
        if (allow_gap)
            while ($urandom_range(0, 99) < 21)
                @(negedge i_clk);
        start = 1'b1;
        i_pos_x = px; i_pos_y = py; i_pos_z = pz;
        i_dest_x = dx; i_dest_y = dy; i_dest_z = dz;
        i_head_x = hx; i_head_y = hy; i_head_z = hz;
        i_speed = spd; i_time_step = ts; i_active = act;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic random_agent(bit allow_gap);
        logic [31:0] p[3];
        logic [31:0] t[3];
        logic [30:0] spd;
        for (int i = 0; i < 3; i++) begin
            p[i] = rand_coord();
            t[i] = ($urandom_range(0, 4) == 0) ? p[i] + $urandom_range(0, 20000) - 10000
                                              : rand_coord();
        end
        spd = ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(0, 50000000));
        send_agent(p[0], p[1], p[2], t[0], t[1], t[2], 16'($urandom), 16'($urandom),
            16'($urandom), spd, 16'($urandom), $urandom_range(0, 9) != 0, allow_gap);
    endtask

    initial begin
        bit fail_seen;
        i_rst_n = 1'b0; start = 1'b0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_dest_x = '0; i_dest_y = '0; i_dest_z = '0;
        i_head_x = '0; i_head_y = '0; i_head_z = '0;
        i_speed = '0; i_time_step = '0; i_active = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset threshold
        send_agent(0, 0, 0, 0, 0, 0, 16'h1234, 16'h8000, 16'h7fff, 31'h7fffffff, 16'hffff, 1, 0);
        send_agent(0, 0, 0, 1000, 0, 0, 1, 2, 3, 5, 5, 1, 0);
        send_agent(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
            32'h7fffffff, 0, 0, 0, 31'h7fffffff, 16'hffff, 1, 0);
        send_agent(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
            32'h80000000, 0, 0, 0, 31'h7fffffff, 16'h0001, 1, 0);
        send_agent(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 31'h10000, 16'h8000, 1, 0);
        send_agent(0, 0, 0, 0, 32'h80000000, 0, 0, 0, 0, 31'h10000, 16'h8000, 1, 0);
        send_agent(0, 0, 0, 0, 0, 32'h00100000, 0, 0, 0, 31'h00100000, 16'hffff, 1, 0);
        send_agent(0, 0, 0, 0, 0, 32'h00100000, 0, 0, 0, 31'h00100000, 16'h0000, 1, 0);
        send_agent(5, 6, 7, 100, 200, 300, 16'h8000, 16'h7fff, 16'h5555,
            31'h7fffffff, 16'hffff, 0, 0);
        send_agent(32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 16'hffff, 16'hffff, 16'hffff,
            31'h0, 16'h0, 0, 0);
        send_agent(0, 0, 0, 0, 0, 32'd10000, 0, 0, 0, 31'h10000, 16'h100, 1, 0);
        drain();
        write_thresh(32'd0);
        send_agent(0, 0, 0, 0, 0, 0, 1, 1, 1, 100, 100, 1, 0);
        send_agent(0, 0, 0, 1, 0, 0, 0, 0, 0, 31'h7fffffff, 16'hffff, 1, 0);
        send_agent(0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0, 1, 0);
        drain();
        write_thresh(32'hffffffff);
        send_agent(0, 0, 0, 32'h7fffffff, 0, 0, 0, 0, 0, 31'h100, 16'h100, 1, 0);
        send_agent(32'h80000000, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0,
            31'h100, 16'h100, 1, 0);
        drain();

        // random phases, several thresholds
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_thresh(32'd6554);
                1: write_thresh(32'd0);
                2: write_thresh($urandom_range(0, 2000000));
                3: write_thresh(32'h7fffffff);
                default: write_thresh($urandom_range(0, 100000));
            endcase
            for (int n = 0; n < 105; n++)
                random_agent(ph != 2);
            drain();
        end

        fail_seen = fail_count != 0;
        if (!fail_seen)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
